// ----- sv/qibm_pkg.sv -----
package qibm_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int OUT_W     = 32;
	localparam int SUM_W     = COORD_W + 4;
	localparam int PRD_W     = 2 * SUM_W;
	localparam int Q_W       = PRD_W + 2;
	localparam int HALF_W    = (Q_W + 1) / 2;
	localparam int HI_W      = Q_W - HALF_W;
	localparam int PP_W      = 2 * HALF_W;
	localparam int DL_W      = 2 * Q_W + 2;
	localparam int R_W       = DL_W / 2;
	localparam int RM_W      = R_W + 3;
	localparam int N_W       = R_W + 3;
	localparam int E_W       = OUT_W + SUM_W + 1;
	localparam int MAG_W     = N_W;
	localparam int DV_W      = MAG_W + OUT_W + 2;
	localparam int DIV_LAT   = OUT_W + 3;
	localparam int PIPE_LAT  = 7 + R_W + 3 + 2 * DIV_LAT + 4 + 1;

	localparam longint unsigned LIM_A = (64'd1 << (2 * FRAC_BITS)) / 64'd100000;
	localparam longint unsigned LIM_D = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000000;

	localparam logic [2:0] ST_LINEAR   = 3'd0;
	localparam logic [2:0] ST_QUAD     = 3'd1;
	localparam logic [2:0] ST_DOUBLE   = 3'd2;
	localparam logic [2:0] ST_OUTSIDE  = 3'd3;
	localparam logic [2:0] ST_COMPLEX  = 3'd4;
	localparam logic [2:0] ST_ZERO_DIV = 3'd5;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [Q_W-1:0]     q_t;
	typedef logic signed [N_W-1:0]     n_t;
	typedef logic signed [E_W-1:0]     e_t;
	typedef logic signed [OUT_W-1:0]   out_t;

	typedef struct packed {
		coord_t corner1_x;
		coord_t corner1_y;
		coord_t corner2_x;
		coord_t corner2_y;
		coord_t corner3_x;
		coord_t corner3_y;
		coord_t corner4_x;
		coord_t corner4_y;
		coord_t point_x;
		coord_t point_y;
	} item_t;

	typedef struct packed {
		out_t       local_ksi;
		out_t       local_eta;
		logic [2:0] status;
	} result_t;

	typedef struct packed {
		sum_t a1;
		sum_t a2;
		sum_t a3;
		sum_t a4;
		sum_t b1;
		sum_t b2;
		sum_t b3;
		sum_t b4;
	} coef_t;

	typedef struct packed {
		logic [RM_W-1:0] rem;
		logic [R_W-1:0]  root;
		logic [DL_W-1:0] n;
	} sq_st_t;

	typedef struct packed {
		logic [DV_W-1:0]  r;
		logic [DV_W-1:0]  dsh;
		logic [OUT_W-1:0] q;
		logic             ovf;
		logic             neg;
	} div_st_t;

endpackage

// ----- sv/qibm_sqrt_cell.sv -----
module qibm_sqrt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  qibm_pkg::sq_st_t in_st,
	output logic             out_valid,
	output qibm_pkg::sq_st_t out_st
);
	import qibm_pkg::*;

	logic [RM_W-1:0] rem2;
	logic [RM_W-1:0] trial;
	logic            take;

	always_comb begin
		rem2  = {in_st.rem[RM_W-3:0], in_st.n[DL_W-1 -: 2]};
		trial = RM_W'({in_st.root, 2'b01});
		take  = rem2 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_st.rem  <= take ? rem2 - trial : rem2;
		out_st.root <= {in_st.root[R_W-2:0], take};
		out_st.n    <= {in_st.n[DL_W-3:0], 2'b00};
	end

endmodule

// ----- sv/qibm_div_cell.sv -----
module qibm_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  qibm_pkg::div_st_t in_st,
	output logic              out_valid,
	output qibm_pkg::div_st_t out_st
);
	import qibm_pkg::*;

	logic take;

	assign take = in_st.r >= in_st.dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_st.r   <= take ? in_st.r - in_st.dsh : in_st.r;
		out_st.dsh <= in_st.dsh >> 1;
		out_st.q   <= {in_st.q[OUT_W-2:0], take};
		out_st.ovf <= in_st.ovf;
		out_st.neg <= in_st.neg;
	end

endmodule

// ----- sv/qibm_divider.sv -----
module qibm_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [qibm_pkg::MAG_W-1:0] nm,
	input  logic [qibm_pkg::MAG_W-1:0] dm,
	input  logic                       neg,
	output logic                       out_valid,
	output qibm_pkg::out_t             quot
);
	import qibm_pkg::*;

	localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	logic            v_s1;
	logic            v_s2;
	logic [DV_W-1:0] num_s1;
	logic [DV_W-1:0] den_s1;
	logic            neg_s1;
	div_st_t         st_s2;
	div_st_t         st_c [OUT_W+1];
	logic [OUT_W:0]  v_c;
	logic            v_q;
	out_t            quot_q;
	div_st_t         fin;
	logic            big;
	logic [OUT_W-1:0] sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_q  <= v_c[OUT_W];
		end
	end

	always_ff @(posedge clk) begin
		num_s1    <= (DV_W'(nm) << (FRAC_BITS + 1)) + DV_W'(dm);
		den_s1    <= DV_W'(dm) << 1;
		neg_s1    <= neg;
		st_s2.r   <= num_s1;
		st_s2.dsh <= den_s1 << (OUT_W - 1);
		st_s2.q   <= '0;
		st_s2.ovf <= num_s1 >= (den_s1 << OUT_W);
		st_s2.neg <= neg_s1;
	end

	assign st_c[0] = st_s2;
	assign v_c[0]  = v_s2;

	for (genvar gi = 0; gi < OUT_W; gi++) begin : g_cell
		qibm_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_c[gi]),
			.in_st    (st_c[gi]),
			.out_valid(v_c[gi+1]),
			.out_st   (st_c[gi+1])
		);
	end

	always_comb begin
		fin = st_c[OUT_W];
		if (fin.neg) begin
			big = fin.ovf || (fin.q[OUT_W-1] && (|fin.q[OUT_W-2:0]));
			sat = big ? SAT_MIN : OUT_W'(-fin.q);
		end else begin
			big = fin.ovf || fin.q[OUT_W-1];
			sat = big ? SAT_MAX : fin.q;
		end
	end

	always_ff @(posedge clk) begin
		quot_q <= out_t'(sat);
	end

	assign out_valid = v_q;
	assign quot      = quot_q;

endmodule

// ----- sv/quad_inverse_bilinear_map.sv -----
// Channel   Ports               Transfer
// input     start, busy, item   start high while busy low, one transaction per cycle
// result    done, result        done high for one cycle, no backpressure
//
// The pipeline has seven front stages, one sqrt cell per root bit, three root-select
// stages, two divider chains, four eta stages and a result register.
// A new transaction can be taken every cycle while busy is low; throughput is one point per clock.
// busy is high only while arst_n is low and for the first cycle after it.
// Results cannot be held off; each one appears for exactly one cycle.
module quad_inverse_bilinear_map (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  qibm_pkg::item_t   item,
	output logic              done,
	output qibm_pkg::result_t result
);
	import qibm_pkg::*;

	typedef struct packed {
		coef_t coef;
		q_t    a;
		q_t    b;
		q_t    c;
		logic  small_a;
		logic  bzero;
		logic  dneg;
		logic  dzero;
	} ks_side_t;

	typedef struct packed {
		coef_t      coef;
		logic [2:0] status;
		logic       have;
	} ks2_side_t;

	typedef struct packed {
		out_t       ksi;
		logic [2:0] status;
		logic       have;
	} es_t;

	typedef struct packed {
		out_t       ksi;
		logic [2:0] status;
		logic       eta_zero;
	} es2_t;

	function automatic sum_t sx(coord_t v);
		return SUM_W'(v);
	endfunction

	function automatic logic [Q_W-1:0] mag_q(q_t v);
		return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
	endfunction

	function automatic logic [N_W-1:0] mag_n(n_t v);
		return v[N_W-1] ? N_W'(-v) : N_W'(v);
	endfunction

	logic busy_q;
	logic accept;

	logic [7:1] v_s;
	coef_t      coef_s1, coef_s2, coef_s3;
	logic signed [PRD_W-1:0] prod_s2 [8];
	q_t         a_s3, b_s3, c_s3;
	ks_side_t   side_s4, side_s5, side_s6, side_s7, side_in;
	logic [Q_W-1:0] ma_s4, mb_s4, mc_s4;
	logic       sac_s4, sac_s5, sac_s6;
	logic [PP_W-1:0] bll_s5, blh_s5, bhh_s5, cll_s5, clh_s5, chl_s5, chh_s5;
	logic [DL_W-1:0] bsq_s6, pac_s6, delta_s7;
	coef_t      c_in;

	sq_st_t     sq_c [R_W+1];
	logic [R_W:0] v_sq;
	ks_side_t   side_sq_q [R_W];
	ks_side_t   sd;

	logic       v_s8, v_s9, v_s10;
	n_t         n1_s8, n2_s8, den_s8, n1_s9, n2_s9, den_s9;
	ks_side_t   side_s8, side_s9;
	logic       in1_s9, in2_s9;
	n_t         ksel_n, ksel_d;
	logic [2:0] ksel_st;
	logic       ksel_have;
	logic [MAG_W-1:0] knm_s10, kdm_s10;
	logic       kneg_s10;
	ks2_side_t  side_s10;
	ks2_side_t  ks2_q [DIV_LAT];

	logic       kv_div;
	out_t       kq_div;
	ks2_side_t  kd;
	out_t       ksi_m;

	logic       v_s11, v_s12, v_s13, v_s14;
	e_t         kb4_s11, kb2_s11, ka4_s11, ka2_s11;
	coef_t      coef_s11;
	es_t        es_s11, es_s12, es_s13;
	e_t         den_s12, num_s12, den2_s12, num2_s12;
	e_t         den_s13, num_s13, den2_s13, num2_s13;
	logic       small_d_s13, d2zero_s13;
	n_t         esel_n, esel_d;
	logic [MAG_W-1:0] enm_s14, edm_s14;
	logic       eneg_s14;
	es2_t       es_s14;
	es2_t       es2_q [DIV_LAT];

	logic       ev_div;
	out_t       eq_div;
	logic       done_q;
	result_t    result_q;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			v_s    <= '0;
			v_s8   <= 1'b0;
			v_s9   <= 1'b0;
			v_s10  <= 1'b0;
			v_s11  <= 1'b0;
			v_s12  <= 1'b0;
			v_s13  <= 1'b0;
			v_s14  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			v_s    <= {v_s[6:1], accept};
			v_s8   <= v_sq[R_W];
			v_s9   <= v_s8;
			v_s10  <= v_s9;
			v_s11  <= kv_div;
			v_s12  <= v_s11;
			v_s13  <= v_s12;
			v_s14  <= v_s13;
			done_q <= ev_div;
		end
	end

	always_comb begin
		c_in.a1 = sx(item.corner1_x) + sx(item.corner2_x) + sx(item.corner3_x)
			+ sx(item.corner4_x) - (sx(item.point_x) <<< 2);
		c_in.a2 = sx(item.corner1_x) - sx(item.corner2_x) - sx(item.corner3_x)
			+ sx(item.corner4_x);
		c_in.a3 = sx(item.corner1_x) + sx(item.corner2_x) - sx(item.corner3_x)
			- sx(item.corner4_x);
		c_in.a4 = sx(item.corner1_x) - sx(item.corner2_x) + sx(item.corner3_x)
			- sx(item.corner4_x);
		c_in.b1 = sx(item.corner1_y) + sx(item.corner2_y) + sx(item.corner3_y)
			+ sx(item.corner4_y) - (sx(item.point_y) <<< 2);
		c_in.b2 = sx(item.corner1_y) - sx(item.corner2_y) - sx(item.corner3_y)
			+ sx(item.corner4_y);
		c_in.b3 = sx(item.corner1_y) + sx(item.corner2_y) - sx(item.corner3_y)
			- sx(item.corner4_y);
		c_in.b4 = sx(item.corner1_y) - sx(item.corner2_y) + sx(item.corner3_y)
			- sx(item.corner4_y);
	end

	always_ff @(posedge clk) begin
		coef_s1 <= c_in;

		coef_s2    <= coef_s1;
		prod_s2[0] <= coef_s1.a2 * coef_s1.b4;
		prod_s2[1] <= coef_s1.b2 * coef_s1.a4;
		prod_s2[2] <= coef_s1.a1 * coef_s1.b4;
		prod_s2[3] <= coef_s1.a2 * coef_s1.b3;
		prod_s2[4] <= coef_s1.a3 * coef_s1.b2;
		prod_s2[5] <= coef_s1.b1 * coef_s1.a4;
		prod_s2[6] <= coef_s1.a1 * coef_s1.b3;
		prod_s2[7] <= coef_s1.a3 * coef_s1.b1;

		coef_s3 <= coef_s2;
		a_s3    <= prod_s2[0] - prod_s2[1];
		b_s3    <= prod_s2[2] + prod_s2[3] - prod_s2[4] - prod_s2[5];
		c_s3    <= prod_s2[6] - prod_s2[7];

		side_s4.coef    <= coef_s3;
		side_s4.a       <= a_s3;
		side_s4.b       <= b_s3;
		side_s4.c       <= c_s3;
		side_s4.small_a <= mag_q(a_s3) <= Q_W'(LIM_A);
		side_s4.bzero   <= b_s3 == '0;
		side_s4.dneg    <= 1'b0;
		side_s4.dzero   <= 1'b0;
		ma_s4           <= mag_q(a_s3);
		mb_s4           <= mag_q(b_s3);
		mc_s4           <= mag_q(c_s3);
		sac_s4          <= a_s3[Q_W-1] ^ c_s3[Q_W-1];

		side_s5 <= side_s4;
		sac_s5  <= sac_s4;
		bll_s5  <= mb_s4[HALF_W-1:0] * mb_s4[HALF_W-1:0];
		blh_s5  <= mb_s4[HALF_W-1:0] * mb_s4[Q_W-1:HALF_W];
		bhh_s5  <= mb_s4[Q_W-1:HALF_W] * mb_s4[Q_W-1:HALF_W];
		cll_s5  <= ma_s4[HALF_W-1:0] * mc_s4[HALF_W-1:0];
		clh_s5  <= ma_s4[HALF_W-1:0] * mc_s4[Q_W-1:HALF_W];
		chl_s5  <= ma_s4[Q_W-1:HALF_W] * mc_s4[HALF_W-1:0];
		chh_s5  <= ma_s4[Q_W-1:HALF_W] * mc_s4[Q_W-1:HALF_W];

		side_s6 <= side_s5;
		sac_s6  <= sac_s5;
		bsq_s6  <= (DL_W'(bhh_s5) << (2 * HALF_W)) + (DL_W'(blh_s5) << (HALF_W + 1))
			+ DL_W'(bll_s5);
		pac_s6  <= ((DL_W'(chh_s5) << (2 * HALF_W))
			+ ((DL_W'(clh_s5) + DL_W'(chl_s5)) << HALF_W) + DL_W'(cll_s5)) << 2;

		side_s7  <= side_s6;
		delta_s7 <= sac_s6 ? bsq_s6 + pac_s6 : bsq_s6 - pac_s6;
	end

	always_comb begin
		side_in       = side_s7;
		side_in.dneg  = delta_s7[DL_W-1];
		side_in.dzero = delta_s7 == '0;
	end

	assign sq_c[0] = '{rem: '0, root: '0, n: (delta_s7[DL_W-1] ? '0 : delta_s7)};
	assign v_sq[0] = v_s[7];

	for (genvar gi = 0; gi < R_W; gi++) begin : g_sq
		qibm_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_sq[gi]),
			.in_st    (sq_c[gi]),
			.out_valid(v_sq[gi+1]),
			.out_st   (sq_c[gi+1])
		);
	end

	always_ff @(posedge clk) begin
		side_sq_q[0] <= side_in;
		for (int i = 1; i < R_W; i++) begin
			side_sq_q[i] <= side_sq_q[i-1];
		end
	end

	assign sd = side_sq_q[R_W-1];

	always_ff @(posedge clk) begin
		side_s8 <= sd;
		n1_s8   <= N_W'(sd.b) + N_W'(sq_c[R_W].root);
		n2_s8   <= N_W'(sd.b) - N_W'(sq_c[R_W].root);
		den_s8  <= N_W'(sd.a) <<< 1;

		side_s9 <= side_s8;
		n1_s9   <= n1_s8;
		n2_s9   <= n2_s8;
		den_s9  <= den_s8;
		in1_s9  <= mag_n(n1_s8) <= mag_n(den_s8);
		in2_s9  <= mag_n(n2_s8) <= mag_n(den_s8);
	end

	always_comb begin
		ksel_n    = '0;
		ksel_d    = '0;
		ksel_st   = ST_LINEAR;
		ksel_have = 1'b1;
		priority if (side_s9.small_a) begin
			if (side_s9.bzero) begin
				ksel_st   = ST_ZERO_DIV;
				ksel_have = 1'b0;
			end else begin
				ksel_n  = N_W'(side_s9.c);
				ksel_d  = N_W'(side_s9.b);
				ksel_st = ST_LINEAR;
			end
		end else if (side_s9.dneg) begin
			ksel_st   = ST_COMPLEX;
			ksel_have = 1'b0;
		end else if (side_s9.dzero) begin
			ksel_n  = N_W'(side_s9.b);
			ksel_d  = den_s9;
			ksel_st = ST_DOUBLE;
		end else if (in1_s9) begin
			ksel_n  = n1_s9;
			ksel_d  = den_s9;
			ksel_st = ST_QUAD;
		end else if (in2_s9) begin
			ksel_n  = n2_s9;
			ksel_d  = den_s9;
			ksel_st = ST_QUAD;
		end else begin
			ksel_st   = ST_OUTSIDE;
			ksel_have = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		knm_s10         <= mag_n(ksel_n);
		kdm_s10         <= mag_n(ksel_d);
		kneg_s10        <= ksel_n[N_W-1] ^ ksel_d[N_W-1];
		side_s10.coef   <= side_s9.coef;
		side_s10.status <= ksel_st;
		side_s10.have   <= ksel_have;
	end

	qibm_divider u_ksi_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s10),
		.nm       (knm_s10),
		.dm       (kdm_s10),
		.neg      (kneg_s10),
		.out_valid(kv_div),
		.quot     (kq_div)
	);

	always_ff @(posedge clk) begin
		ks2_q[0] <= side_s10;
		for (int i = 1; i < DIV_LAT; i++) begin
			ks2_q[i] <= ks2_q[i-1];
		end
	end

	assign kd    = ks2_q[DIV_LAT-1];
	assign ksi_m = kd.have ? kq_div : '0;

	always_ff @(posedge clk) begin
		coef_s11      <= kd.coef;
		es_s11.ksi    <= ksi_m;
		es_s11.status <= kd.status;
		es_s11.have   <= kd.have;
		kb4_s11       <= ksi_m * kd.coef.b4;
		kb2_s11       <= ksi_m * kd.coef.b2;
		ka4_s11       <= ksi_m * kd.coef.a4;
		ka2_s11       <= ksi_m * kd.coef.a2;

		es_s12   <= es_s11;
		den_s12  <= (E_W'(coef_s11.b3) <<< FRAC_BITS) + kb4_s11;
		num_s12  <= -((E_W'(coef_s11.b1) <<< FRAC_BITS) + kb2_s11);
		den2_s12 <= ka4_s11 + (E_W'(coef_s11.a3) <<< FRAC_BITS);
		num2_s12 <= -((E_W'(coef_s11.a1) <<< FRAC_BITS) + ka2_s11);

		es_s13      <= es_s12;
		den_s13     <= den_s12;
		num_s13     <= num_s12;
		den2_s13    <= den2_s12;
		num2_s13    <= num2_s12;
		small_d_s13 <= mag_n(N_W'(den_s12)) <= N_W'(LIM_D);
		d2zero_s13  <= den2_s12 == '0;
	end

	always_comb begin
		if (small_d_s13) begin
			esel_n = N_W'(num2_s13);
			esel_d = N_W'(den2_s13);
		end else begin
			esel_n = N_W'(num_s13);
			esel_d = N_W'(den_s13);
		end
	end

	always_ff @(posedge clk) begin
		enm_s14         <= mag_n(esel_n);
		edm_s14         <= mag_n(esel_d);
		eneg_s14        <= esel_n[N_W-1] ^ esel_d[N_W-1];
		es_s14.ksi      <= es_s13.ksi;
		es_s14.eta_zero <= !es_s13.have || (small_d_s13 && d2zero_s13);
		es_s14.status   <= (es_s13.have && small_d_s13 && d2zero_s13) ? ST_ZERO_DIV
			: es_s13.status;
	end

	qibm_divider u_eta_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s14),
		.nm       (enm_s14),
		.dm       (edm_s14),
		.neg      (eneg_s14),
		.out_valid(ev_div),
		.quot     (eq_div)
	);

	always_ff @(posedge clk) begin
		es2_q[0] <= es_s14;
		for (int i = 1; i < DIV_LAT; i++) begin
			es2_q[i] <= es2_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		result_q.local_ksi <= es2_q[DIV_LAT-1].ksi;
		result_q.local_eta <= es2_q[DIV_LAT-1].eta_zero ? '0 : eq_div;
		result_q.status    <= es2_q[DIV_LAT-1].status;
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- sv/qibm_checker.sv -----
module qibm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input qibm_pkg::result_t result
);
	import qibm_pkg::*;

	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after reset");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without transaction");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status <= ST_ZERO_DIV))
		else $error("status out of range");

	a_no_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_OUTSIDE || result.status == ST_COMPLEX))
		|-> (result.local_ksi == '0 && result.local_eta == '0))
		else $error("nonzero coordinates without a root");

endmodule

bind quad_inverse_bilinear_map qibm_checker u_qibm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
